// ===== rtl/lbs_pkg.sv =====
// Shared types and codes for the linear blend skinning block.
// Holds the command and result transaction structs, the function codes and the sequencer state type.
// Depends on nothing.
package lbs_pkg;

	typedef enum logic [1:0] {
		FN_PAL_WRITE = 2'd0,
		FN_START     = 2'd1,
		FN_ADD_BONE  = 2'd2,
		FN_TRANSFORM = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLEND,
		ST_XFORM,
		ST_SQ,
		ST_SQRT,
		ST_DIVLD,
		ST_DIV,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [9:0]         palette_addr;
		logic signed [31:0] word;
		logic [5:0]         bone;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic               is_direction;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
	} res_t;

endpackage

// ===== rtl/linear_blend_skinning.sv =====
// Linear blend skinning unit: bone palette, blended matrix and vector transform.
// Depends on lbs_pkg for the transaction structs, function codes and state type.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  cmd     | in        | cmd_valid, cmd_stall | lbs_pkg::cmd_t (func, vector ...)
//  res     | out       | res_valid, res_stall | lbs_pkg::res_t (out_x/y/z)
//
// Palette write and start vertex finish on acceptance. A weighted add runs through acceptance,
// sixteen palette reads through the single palette port, the drain of the two pipeline stages
// and a check that the pipeline is empty. A position transform gives its result after twelve
// matrix reads, the drain and the output load; a direction adds squaring, a digit-by-digit
// square root and bit-serial division of each component by the length.
// Reset clears the sequencer and the blended-matrix valid bits; the palette is not cleared.
// A waiting result does not block new transactions, only the next transform's completion.
module linear_blend_skinning #(
	parameter int BONES     = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  lbs_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output lbs_pkg::res_t res
);
	import lbs_pkg::*;

	localparam int PAL_DEPTH = BONES * 16;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);
	// Division numerator: a 32-bit magnitude shifted up by FRAC_BITS plus one carry bit.
	localparam int NUM_W     = 32 + FRAC_BITS + 1;
	localparam int CNT_W     = $clog2(NUM_W + 1);

	function automatic logic signed [64:0] fx_round(input logic signed [63:0] p);
		logic signed [64:0] s;
		s = 65'(p) + (65'sd1 <<< (FRAC_BITS - 1));
		return s >>> FRAC_BITS;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647)
			r = 32'h7fffffff;
		else if (v < -66'sd2147483648)
			r = 32'h80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] t);
		return t[31] ? (~t + 32'd1) : t;
	endfunction

	state_t state_q, state_d;

	// Storage: the palette and the blended matrix, both with registered reads.
	logic [31:0] pal_mem [PAL_DEPTH];
	logic [31:0] bl_mem  [16];
	logic [15:0] bl_vld_q;

	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         k_q;
	logic signed [31:0] word_q;
	logic [PAL_AW-1:0]  bone_base_q;
	logic signed [31:0] vec_q [3];
	logic               dir_q;
	logic signed [31:0] t_q [3];

	// Read/multiply/accumulate pipeline shared by weighted add and transform.
	logic               iss;
	logic [3:0]         rd_idx;
	logic [31:0]        pal_rd_s1;
	logic [31:0]        bl_rd_s1;
	logic               blv_s1;
	logic [3:0]         addr_s1;
	logic               v_s1;
	logic signed [63:0] prod_s2;
	logic signed [31:0] m_s2;
	logic [3:0]         addr_s2;
	logic               v_s2;
	logic signed [65:0] acc_q;
	logic signed [31:0] bl_eff_s1;
	logic signed [31:0] mul_a, mul_b;
	logic signed [65:0] term;
	logic signed [65:0] blend_sum;

	// Normalization.
	logic [63:0]        sqp_q, sq_q;
	logic [63:0]        n_q, rt_q, bit_q;
	logic [31:0]        len_q;
	logic [31:0]        rem_q;
	logic [NUM_W-1:0]   num_q;
	logic [32:0]        rem2;
	logic               qbit;
	logic [31:0]        mag_k;
	logic signed [65:0] q_signed;

	res_t res_q;
	logic res_valid_q;

	logic cmd_take;
	logic pipe_empty;
	logic put_ok;
	logic [31:0] wr_addr_wide;
	logic [31:0] bone_base_wide;

	assign cmd_take   = cmd_valid && !cmd_stall;
	assign pipe_empty = !v_s1 && !v_s2;
	assign put_ok     = !res_valid_q || !res_stall;
	assign wr_addr_wide   = 32'(cmd.palette_addr);
	assign bone_base_wide = 32'(cmd.bone) << 4;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = (state_q != ST_IDLE);
		iss       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (func_t'(cmd.func))
						FN_ADD_BONE: begin
							if (32'(cmd.bone) < 32'(BONES))
								state_d = ST_BLEND;
						end
						FN_TRANSFORM: state_d = ST_XFORM;
						default: ;
					endcase
				end
			end
			ST_BLEND: begin
				iss = (cnt_q < CNT_W'(16));
				if (!iss && pipe_empty)
					state_d = ST_IDLE;
			end
			ST_XFORM: begin
				iss = (cnt_q < CNT_W'(12));
				if (!iss && pipe_empty)
					state_d = dir_q ? ST_SQ : ST_PUT;
			end
			ST_SQ: begin
				if (cnt_q == CNT_W'(3))
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (cnt_q == CNT_W'(31))
					state_d = ST_DIVLD;
			end
			ST_DIVLD: begin
				// A zero-length direction gives a zero result without dividing.
				if (len_q == 32'd0)
					state_d = ST_PUT;
				else
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(NUM_W)) begin
					if (k_q == 2'd2)
						state_d = ST_PUT;
					else
						state_d = ST_DIVLD;
				end
			end
			ST_PUT: begin
				if (put_ok)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rd_idx = cnt_q[3:0];

	// Palette memory: written by palette-write transactions, read one word per cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_take && func_t'(cmd.func) == FN_PAL_WRITE &&
		    wr_addr_wide < 32'(PAL_DEPTH))
			pal_mem[wr_addr_wide[PAL_AW-1:0]] <= cmd.word;
		pal_rd_s1 <= pal_mem[bone_base_q + PAL_AW'(rd_idx)];
	end

	// Blended matrix memory: the write-back of entry c is made from pipeline stage two, after its
	// read, and each weighted add touches every entry once, so no read ever sees a pending write.
	always_ff @(posedge clk) begin
		if (v_s2 && state_q == ST_BLEND)
			bl_mem[addr_s2] <= sat32(blend_sum);
		bl_rd_s1 <= bl_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_vld_q <= '0;
			blv_s1   <= 1'b0;
		end else begin
			blv_s1 <= bl_vld_q[rd_idx];
			if (state_q == ST_IDLE && cmd_take && func_t'(cmd.func) == FN_START)
				bl_vld_q <= '0;
			else if (v_s2 && state_q == ST_BLEND)
				bl_vld_q[addr_s2] <= 1'b1;
		end
	end

	assign bl_eff_s1 = blv_s1 ? bl_rd_s1 : 32'sd0;

	always_comb begin
		if (state_q == ST_BLEND) begin
			mul_a = word_q;
			mul_b = pal_rd_s1;
		end else begin
			mul_a = bl_eff_s1;
			case (addr_s1[1:0])
				2'd0:    mul_b = vec_q[0];
				2'd1:    mul_b = vec_q[1];
				2'd2:    mul_b = vec_q[2];
				default: mul_b = 32'sd0;
			endcase
		end
	end

	assign blend_sum = 66'(m_s2) + 66'(fx_round(prod_s2));

	// The translation column adds exactly for a position and drops out for a direction.
	always_comb begin
		if (addr_s2[1:0] == 2'd3)
			term = dir_q ? 66'sd0 : 66'(m_s2);
		else
			term = 66'(fx_round(prod_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= iss;
			v_s2 <= v_s1;
			if (state_q == ST_PUT && put_ok)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// Datapath registers; control lives in the blocks above.
	always_ff @(posedge clk) begin
		addr_s1 <= rd_idx;
		prod_s2 <= mul_a * mul_b;
		m_s2    <= bl_eff_s1;
		addr_s2 <= addr_s1;

		case (state_q)
			ST_IDLE: begin
				cnt_q       <= '0;
				k_q         <= 2'd0;
				acc_q       <= '0;
				sqp_q       <= '0;
				sq_q        <= '0;
				word_q      <= cmd.word;
				bone_base_q <= bone_base_wide[PAL_AW-1:0];
				vec_q[0]    <= cmd.vec_x;
				vec_q[1]    <= cmd.vec_y;
				vec_q[2]    <= cmd.vec_z;
				dir_q       <= cmd.is_direction;
			end
			ST_BLEND: begin
				if (iss)
					cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_XFORM: begin
				if (iss)
					cnt_q <= cnt_q + CNT_W'(1);
				else if (pipe_empty)
					cnt_q <= '0;
				if (v_s2) begin
					if (addr_s2[1:0] == 2'd3) begin
						case (addr_s2[3:2])
							2'd0:    t_q[0] <= sat32(acc_q + term);
							2'd1:    t_q[1] <= sat32(acc_q + term);
							default: t_q[2] <= sat32(acc_q + term);
						endcase
						acc_q <= '0;
					end else begin
						acc_q <= acc_q + term;
					end
				end
			end
			ST_SQ: begin
				// Square one component per cycle and add the previous square.
				if (cnt_q < CNT_W'(3))
					sqp_q <= 64'(mag_k) * 64'(mag_k);
				sq_q <= sq_q + sqp_q;
				if (cnt_q == CNT_W'(3)) begin
					cnt_q <= '0;
					n_q   <= sq_q + sqp_q;
					rt_q  <= '0;
					bit_q <= 64'd1 << 62;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_SQRT: begin
				// One result bit per cycle of the digit-by-digit integer square root.
				if (n_q >= rt_q + bit_q) begin
					n_q  <= n_q - (rt_q + bit_q);
					rt_q <= (rt_q >> 1) + bit_q;
				end else begin
					rt_q <= rt_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (cnt_q == CNT_W'(31)) begin
					cnt_q <= '0;
					if (n_q >= rt_q + bit_q)
						len_q <= 32'((rt_q >> 1) + bit_q);
					else
						len_q <= 32'(rt_q >> 1);
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_DIVLD: begin
				cnt_q <= '0;
				rem_q <= '0;
				num_q <= (NUM_W'(mag_k) << FRAC_BITS) + NUM_W'(len_q >> 1);
				if (len_q == 32'd0) begin
					t_q[0] <= 32'sd0;
					t_q[1] <= 32'sd0;
					t_q[2] <= 32'sd0;
				end
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(NUM_W)) begin
					case (k_q)
						2'd0:    t_q[0] <= sat32(q_signed);
						2'd1:    t_q[1] <= sat32(q_signed);
						default: t_q[2] <= sat32(q_signed);
					endcase
					k_q <= k_q + 2'd1;
				end else begin
					rem_q <= qbit ? 32'(rem2 - {1'b0, len_q}) : rem2[31:0];
					num_q <= {num_q[NUM_W-2:0], qbit};
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_PUT: begin
				if (put_ok) begin
					res_q.out_x <= t_q[0];
					res_q.out_y <= t_q[1];
					res_q.out_z <= t_q[2];
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (state_q == ST_SQ ? cnt_q[1:0] : k_q)
			2'd0:    mag_k = mag32(t_q[0]);
			2'd1:    mag_k = mag32(t_q[1]);
			2'd2:    mag_k = mag32(t_q[2]);
			default: mag_k = 32'd0;
		endcase
	end

	// Restoring division step: the remainder stays below the 32-bit divisor.
	assign rem2 = {rem_q, num_q[NUM_W-1]};
	assign qbit = (rem2 >= {1'b0, len_q});

	always_comb begin
		case (k_q)
			2'd0:    q_signed = t_q[0][31] ? -66'({1'b0, num_q}) : 66'({1'b0, num_q});
			2'd1:    q_signed = t_q[1][31] ? -66'({1'b0, num_q}) : 66'({1'b0, num_q});
			default: q_signed = t_q[2][31] ? -66'({1'b0, num_q}) : 66'({1'b0, num_q});
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	// The blend pipeline only carries entries while a sequence owns it.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ST_BLEND || state_q == ST_XFORM))
		else $error("pipeline active outside blend or transform");

	// Normalization is entered only for directions.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> dir_q)
		else $error("square root entered for a position");

	// The divider never runs with a zero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (len_q != 32'd0))
		else $error("division by zero length");

	// A new result is loaded only when the output register is free or being emptied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |=> res_valid_q)
		else $error("waiting result dropped");
`endif

endmodule
